[hdl/gated_normalized_spectrum_average_defines.svh]
// assertion macros shared by the spectrum average rtl
`ifndef GATED_NORMALIZED_SPECTRUM_AVERAGE_DEFINES_SVH
`define GATED_NORMALIZED_SPECTRUM_AVERAGE_DEFINES_SVH

// same-cycle implication, off during reset
`define GNSA_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define GNSA_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gnsa_pkg.sv]
package gnsa_pkg;

  localparam int CHANNELS_DEF = 1024;

  // item kinds
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_TIC_LOW  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_TIC_HIGH = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_CHANNELS = 2'd2;

  localparam logic [31:0] TIC_LOW_RST  = 32'd1;
  localparam logic [31:0] TIC_HIGH_RST = 32'hFFFF_FFFF;
  localparam logic [10:0] CHANS_RST    = 11'd1024;

  // radix-4 divider steps: 48-bit quotient for an add, 64-bit for a read
  localparam int DIV_STEPS_ADD  = 24;
  localparam int DIV_STEPS_READ = 32;

endpackage

[hdl/gnsa_ram.sv]
module gnsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/gated_normalized_spectrum_average.sv]
// gated, count-normalized mean spectrum
//
// in_ channel: kind, channel, intensity and pixel_tic under valid/stall.
// kind add folds intensity * 2^24 / pixel_tic into the channel's 64-bit sum
// when the pixel's count lies in [tic_low, tic_high] and is not zero; the
// pixel counter steps on the last active channel. kind read returns the
// channel mean (sum / pixels), kind clear empties the store.
// out_ channel: one item per read, held in an output register while
// out_stall is high; the block goes on accepting adds meanwhile, and a
// read that finishes while that register is still full waits for it.
// cfg_ port: plain writes; the user must make them while the block is idle,
// which the block does not enforce. one shared radix-4 divider (two quotient
// bits a cycle) serves both kinds, and the sum memory has its own read and
// write ports: an add runs fetch, 24 divide steps and write back, a read
// fetch, 32 steps and out_valid rising; a rejected add or unused kind leaves
// the block idle, a read with no pixel or an out-of-range channel goes
// straight to its finish step. reset and clear: a zeroing pass over the
// memory with in_stall high; configuration writes are still taken.
module gated_normalized_spectrum_average
  import gnsa_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic [9:0]          in_channel,
  input  logic [23:0]         in_intensity,
  input  logic [31:0]         in_pixel_tic,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [47:0]         out_mean_value,
  output logic [31:0]         out_pixels_used,
  output logic [9:0]          out_read_channel,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [31:0]         cfg_wdata
);

`include "gated_normalized_spectrum_average_defines.svh"

  localparam int AW = $clog2(CHANNELS);
  localparam int NW = $clog2(CHANNELS + 1);
  localparam int EW = (NW > 11) ? NW : 11;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state_r;

  logic [31:0]   tic_low_r;
  logic [31:0]   tic_high_r;
  logic [10:0]   chans_r;
  logic [31:0]   pixel_total_r;
  logic [AW-1:0] clr_addr_r;

  // accepted item
  logic          is_read_r;
  logic          read_ok_r;
  logic          last_r;
  logic [9:0]    chan_r;
  logic [AW-1:0] addr_r;
  logic [23:0]   inten_r;
  logic [31:0]   tic_r;

  // divider
  logic [63:0]   dvd_r;
  logic [63:0]   quo_r;
  logic [31:0]   rem_r;
  logic [31:0]   d1_r;
  logic [33:0]   d3_r;
  logic [4:0]    cnt_r;

  logic          out_valid_r;
  logic [47:0]   out_mean_r;
  logic [31:0]   out_pixels_r;
  logic [9:0]    out_chan_r;

  logic          in_acc;
  logic [EW-1:0] chan_ext;
  logic [EW-1:0] chans_ext;
  logic [EW-1:0] chan_max;
  logic [EW-1:0] n_act;
  logic          add_ok;
  logic          read_ok;
  logic [AW-1:0] in_addr;

  logic [31:0]   d_sel;
  logic [33:0]   d3_nxt;
  logic [33:0]   part;
  logic [34:0]   diff1;
  logic [34:0]   diff2;
  logic [34:0]   diff3;
  logic [1:0]    digit;
  logic [31:0]   rem_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;
  logic [64:0]   sum_wide;
  logic [63:0]   sum_nxt;
  logic [47:0]   mean_nxt;
  logic          out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // active channel count: zero acts as one, clipped to the store depth
  assign chan_ext  = EW'(in_channel);
  assign chans_ext = EW'(chans_r);
  assign chan_max  = EW'(CHANNELS);
  always_comb begin
    if (chans_ext == '0) begin
      n_act = EW'(1);
    end else if (chans_ext > chan_max) begin
      n_act = chan_max;
    end else begin
      n_act = chans_ext;
    end
  end

  assign add_ok = (chan_ext < n_act) && (in_pixel_tic != '0) &&
                  (in_pixel_tic >= tic_low_r) && (in_pixel_tic <= tic_high_r);
  assign read_ok = (pixel_total_r != '0) && (chan_ext < chan_max);
  assign in_addr = chan_ext[AW-1:0];

  // radix-4 restoring step against d, 2d and 3d
  assign d_sel  = is_read_r ? pixel_total_r : tic_r;
  assign d3_nxt = {2'b00, d_sel} + {1'b0, d_sel, 1'b0};
  assign part   = {rem_r, dvd_r[63:62]};
  assign diff3  = {1'b0, part} - {1'b0, d3_r};
  assign diff2  = {1'b0, part} - {2'b00, d1_r, 1'b0};
  assign diff1  = {1'b0, part} - {3'b000, d1_r};
  always_comb begin
    if (!diff3[34]) begin
      digit   = 2'd3;
      rem_nxt = diff3[31:0];
    end else if (!diff2[34]) begin
      digit   = 2'd2;
      rem_nxt = diff2[31:0];
    end else if (!diff1[34]) begin
      digit   = 2'd1;
      rem_nxt = diff1[31:0];
    end else begin
      digit   = 2'd0;
      rem_nxt = part[31:0];
    end
  end

  // saturating accumulate; an add quotient never exceeds 48 bits
  assign sum_wide = {1'b0, ram_rdata} + 65'(quo_r[47:0]);
  assign sum_nxt  = sum_wide[64] ? '1 : sum_wide[63:0];
  assign mean_nxt = !read_ok_r ? '0 :
                    (quo_r[63:48] != '0) ? '1 : quo_r[47:0];

  assign out_free = !out_valid_r || !out_stall;

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_FINISH && !is_read_r);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : sum_nxt;

  gnsa_ram #(
    .WIDTH (64),
    .DEPTH (CHANNELS)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      pixel_total_r <= '0;
      out_valid_r   <= 1'b0;
      tic_low_r     <= TIC_LOW_RST;
      tic_high_r    <= TIC_HIGH_RST;
      chans_r       <= CHANS_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TIC_LOW:  tic_low_r  <= cfg_wdata;
          CFG_TIC_HIGH: tic_high_r <= cfg_wdata;
          CFG_CHANNELS: chans_r    <= cfg_wdata[10:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(CHANNELS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            chan_r    <= in_channel;
            addr_r    <= in_addr;
            inten_r   <= in_intensity;
            tic_r     <= in_pixel_tic;
            last_r    <= (chan_ext == n_act - EW'(1));
            read_ok_r <= read_ok;
            unique case (in_kind)
              KIND_ADD: begin
                is_read_r <= 1'b0;
                if (add_ok) begin
                  state_r <= S_FETCH;
                end
              end
              KIND_READ: begin
                is_read_r <= 1'b1;
                state_r   <= read_ok ? S_FETCH : S_FINISH;
              end
              KIND_CLEAR: begin
                pixel_total_r <= '0;
                clr_addr_r    <= '0;
                state_r       <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          dvd_r   <= is_read_r ? ram_rdata : {inten_r, 40'd0};
          quo_r   <= '0;
          rem_r   <= '0;
          d1_r    <= d_sel;
          d3_r    <= d3_nxt;
          cnt_r   <= is_read_r ? 5'(DIV_STEPS_READ - 1) : 5'(DIV_STEPS_ADD - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          dvd_r <= {dvd_r[61:0], 2'b00};
          quo_r <= {quo_r[61:0], digit};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!is_read_r) begin
            if (last_r && pixel_total_r != '1) begin
              pixel_total_r <= pixel_total_r + 32'd1;
            end
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_mean_r   <= mean_nxt;
            out_pixels_r <= pixel_total_r;
            out_chan_r   <= chan_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mean_value   = out_mean_r;
  assign out_pixels_used  = out_pixels_r;
  assign out_read_channel = out_chan_r;

  `GNSA_HOLDS(a_no_write_in_div, state_r == S_DIV, !ram_we, "sum memory written while dividing")
  `GNSA_NEXT(a_total_stable_in_div, state_r == S_DIV, $stable(pixel_total_r), "pixel count moved mid-divide")
  `GNSA_NEXT(a_read_waits_for_out, state_r == S_FINISH && is_read_r && out_valid_r && out_stall, state_r == S_FINISH && out_valid_r, "read result overwrote a pending item")
  `GNSA_HOLDS(a_step_count_bound, state_r == S_DIV && !is_read_r, cnt_r <= 5'(DIV_STEPS_ADD - 1), "add divide ran past its steps")

endmodule

[tb/tb_gated_normalized_spectrum_average.sv]
module tb_gated_normalized_spectrum_average;
  import gnsa_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = CHANNELS_DEF + 80;
  localparam int LIMIT_TIME = 10_000_000;
  localparam int PHASE_BUDGET = 150;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  channel;
    logic [23:0] intensity;
    logic [31:0] pixel_tic;
  } spectrum_item_t;

  typedef struct packed {
    logic [47:0] mean;
    logic [31:0] pixels;
    logic [9:0]  channel;
  } channel_mean_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [9:0] in_channel = '0;
  logic [23:0] in_intensity = '0;
  logic [31:0] in_pixel_tic = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [47:0] out_mean_value;
  logic [31:0] out_pixels_used;
  logic [9:0] out_read_channel;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // mirror of the block's store and registers
  logic [63:0] sum_mirror [CHANNELS_DEF];
  logic [31:0] pixel_tally;
  logic [31:0] win_low = TIC_LOW_RST;
  logic [31:0] win_high = TIC_HIGH_RST;
  logic [10:0] chan_count = CHANS_RST;

  spectrum_item_t pending_items[$];
  channel_mean_t awaited_means[$];
  spectrum_item_t cur_item;
  channel_mean_t want;

  int send_wait = 0;
  int send_calm = 0;
  int hold_left = 0;
  int hold_calm = 0;
  int mismatches = 0;
  int items_accepted = 0;
  int means_checked = 0;
  int rejected_adds = 0;
  int ignored_adds = 0;
  int clears_seen = 0;
  int saturated_means = 0;
  int settings_used = 0;

  gated_normalized_spectrum_average dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_channel       (in_channel),
    .in_intensity     (in_intensity),
    .in_pixel_tic     (in_pixel_tic),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mean_value   (out_mean_value),
    .out_pixels_used  (out_pixels_used),
    .out_read_channel (out_read_channel),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [10:0] effective_channels();
    if (chan_count == 11'd0) return 11'd1;
    if (chan_count > 11'(CHANNELS_DEF)) return 11'(CHANNELS_DEF);
    return chan_count;
  endfunction

  function automatic void empty_store();
    for (int i = 0; i < CHANNELS_DEF; i++) sum_mirror[i] = '0;
    pixel_tally = '0;
  endfunction

  // folds one accepted item into the mirror, queues the average a read returns
  function automatic void apply_to_spectrum(input spectrum_item_t it);
    logic [10:0] n;
    logic [47:0] quot;
    logic [64:0] total;
    logic [63:0] ratio;
    channel_mean_t res;
    n = effective_channels();
    case (it.kind)
      KIND_ADD: begin
        if ({1'b0, it.channel} >= n) begin
          ignored_adds++;
        end else if (it.pixel_tic == 32'd0 || it.pixel_tic < win_low ||
                     it.pixel_tic > win_high) begin
          rejected_adds++;
        end else begin
          // 24-bit intensity over a nonzero count always fits in 48 bits
          quot = {it.intensity, 24'd0} / {16'd0, it.pixel_tic};
          total = {1'b0, sum_mirror[it.channel]} + {17'd0, quot};
          sum_mirror[it.channel] = total[64] ? '1 : total[63:0];
          if ({1'b0, it.channel} == n - 11'd1 && pixel_tally != '1) pixel_tally++;
        end
      end
      KIND_READ: begin
        res.mean = '0;
        if (pixel_tally != 32'd0) begin
          ratio = sum_mirror[it.channel] / {32'd0, pixel_tally};
          if (ratio > 64'hFFFF_FFFF_FFFF) begin
            res.mean = '1;
            saturated_means++;
          end else begin
            res.mean = ratio[47:0];
          end
        end
        res.pixels = pixel_tally;
        res.channel = it.channel;
        awaited_means = {awaited_means, res};
      end
      KIND_CLEAR: begin
        empty_store();
        clears_seen++;
      end
      default: ;
    endcase
  endfunction

  // idle cycles before the next item, with runs of back-to-back items
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [31:0] pick_tic(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2: return lo - 32'd1;
      3: return hi + 32'd1;
      4: return 32'd0;
      5: return $urandom();
      6: return $urandom_range(1, 16);
      default: return (lo <= hi) ? $urandom_range(hi, lo) : $urandom();
    endcase
  endfunction

  function automatic logic [23:0] pick_intensity();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(0, 255));
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic void push_item(input logic [1:0] kind, input int unsigned chan,
                                    input int unsigned inten, input logic [31:0] tic);
    spectrum_item_t it;
    it.kind = kind;
    it.channel = chan[9:0];
    it.intensity = inten[23:0];
    it.pixel_tic = tic;
    pending_items = {pending_items, it};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (mismatches < 40)
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  // waits until the sender has run dry and every average is back, then the block settles
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || awaited_means.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TIC_LOW:  win_low = val;
      CFG_TIC_HIGH: win_high = val;
      CFG_CHANNELS: chan_count = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] chans);
    write_reg(CFG_TIC_LOW, lo);
    write_reg(CFG_TIC_HIGH, hi);
    write_reg(CFG_CHANNELS, chans);
    settings_used++;
  endtask

  // mostly whole pixels over the active channels, mixed with reads and noise
  task automatic queue_random_phase(input int budget);
    int queued;
    int n;
    int r;
    logic [31:0] tic;
    queued = 0;
    n = int'(effective_channels());
    while (queued < budget) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        tic = pick_tic(win_low, win_high);
        if (n <= 16) begin
          for (int c = 0; c < n; c++) push_item(KIND_ADD, c, pick_intensity(), tic);
          queued += n;
        end else begin
          for (int k = 0; k < 6; k++)
            push_item(KIND_ADD, $urandom_range(0, n - 1), pick_intensity(), tic);
          push_item(KIND_ADD, n - 1, pick_intensity(), tic);
          queued += 7;
        end
      end else if (r < 82) begin
        push_item(KIND_READ, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                  : $urandom_range(0, n - 1), pick_intensity(), $urandom());
        queued++;
      end else if (r < 96) begin
        push_item(KIND_ADD, $urandom_range(0, 1023), pick_intensity(),
                  pick_tic(win_low, win_high));
        queued++;
      end else if (r < 97) begin
        push_item(KIND_CLEAR, $urandom_range(0, 1023), pick_intensity(), $urandom());
        queued++;
      end else begin
        push_item(KIND_UNUSED, $urandom_range(0, 1023), pick_intensity(), $urandom());
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_to_spectrum(cur_item);
        items_accepted++;
        send_wait = pick_wait(send_calm);
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_kind <= cur_item.kind;
          in_channel <= cur_item.channel;
          in_intensity <= cur_item.intensity;
          in_pixel_tic <= cur_item.pixel_tic;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_means.size() == 0) begin
          report_mismatch("average with none pending, channel", 64'(out_read_channel), 64'd0);
        end else begin
          want = awaited_means.pop_front();
          means_checked++;
          if (out_mean_value !== want.mean)
            report_mismatch("mean_value", 64'(out_mean_value), 64'(want.mean));
          if (out_pixels_used !== want.pixels)
            report_mismatch("pixels_used", 64'(out_pixels_used), 64'(want.pixels));
          if (out_read_channel !== want.channel)
            report_mismatch("read_channel", 64'(out_read_channel), 64'(want.channel));
        end
        hold_left = pick_wait(hold_calm);
      end else if (out_valid && hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  initial begin
    #LIMIT_TIME;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    empty_store();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // reset settings: empty reads, saturated mean, zero count, tiny quotients
    push_item(KIND_READ, 0, 0, 0);
    push_item(KIND_ADD, 1023, 24'hFF_FFFF, 1);
    repeat (3) push_item(KIND_ADD, 0, 24'hFF_FFFF, 1);
    push_item(KIND_READ, 0, 0, 0);
    push_item(KIND_READ, 1023, 0, 0);
    push_item(KIND_ADD, 5, 100, 0);
    push_item(KIND_ADD, 5, 0, 32'hFFFF_FFFF);
    push_item(KIND_ADD, 5, 1, 32'hFFFF_FFFF);
    push_item(KIND_ADD, 5, 12345, 7);
    push_item(KIND_UNUSED, 5, 24'hFF_FFFF, 32'hFFFF_FFFF);
    push_item(KIND_READ, 5, 0, 0);
    push_item(KIND_CLEAR, 0, 0, 0);
    push_item(KIND_READ, 0, 0, 0);
    push_item(KIND_READ, 1023, 0, 0);
    settle();

    // zero channel count acts as one, adds past it are dropped
    set_window(32'd0, 32'hFFFF_FFFF, 32'd0);
    push_item(KIND_ADD, 0, 500, 0);
    push_item(KIND_ADD, 0, 500, 3);
    push_item(KIND_ADD, 1, 500, 3);
    push_item(KIND_READ, 0, 0, 0);
    push_item(KIND_READ, 1, 0, 0);
    settle();

    // inverted window rejects everything, oversize count acts as full
    set_window(32'd100, 32'd50, 32'd2047);
    push_item(KIND_ADD, 1023, 24'hFF_FFFF, 75);
    push_item(KIND_READ, 1023, 0, 0);
    settle();

    set_window(32'd1, 32'hFFFF_FFFF, 32'd4);
    queue_random_phase(PHASE_BUDGET);
    settle();
    set_window(32'd1000, 32'd50000, 32'd3);
    queue_random_phase(PHASE_BUDGET);
    settle();
    set_window(32'd0, 32'hFFFF_FFFF, 32'd1);
    queue_random_phase(PHASE_BUDGET);
    settle();
    set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
    queue_random_phase(PHASE_BUDGET);
    settle();
    set_window(TIC_LOW_RST, TIC_HIGH_RST, 32'(CHANS_RST));
    queue_random_phase(PHASE_BUDGET);
    settle();
    set_window($urandom_range(1, 5000), $urandom_range(5000, 32'hFFFF_FFFF),
               $urandom_range(1, 8));
    queue_random_phase(PHASE_BUDGET);
    settle();

    $display("%0d items accepted over %0d register settings: %0d adds outside the window,",
             items_accepted, settings_used, rejected_adds);
    $display("%0d past the active channels, %0d clears, %0d averages checked (%0d saturated)",
             ignored_adds, clears_seen, means_checked, saturated_means);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
